>>> rtl/core/cbm_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_pkg: shared types and constants of the collision brake monitor
// Event codes, register map, reset values and the job passed from the front
// end to the divider back end.
// ---------------------------------------------------------------------------
package cbm_pkg;

	localparam logic [1:0] CMD_SPEED = 2'd0;
	localparam logic [1:0] CMD_CAR   = 2'd1;
	localparam logic [1:0] CMD_LIMIT = 2'd2;

	localparam logic REG_THRESHOLD = 1'b0;

	localparam logic [15:0] THRESHOLD_RESET = 16'd1280;
	localparam logic [15:0] THRESHOLD_MIN   = 16'd256;
	localparam logic signed [15:0] LIMIT_RESET = 16'sd9984;

	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic {
		JOB_ZERO,
		JOB_DIVIDE
	} cbm_op_t;

	typedef struct packed {
		cbm_op_t     op;
		logic [15:0] distance;
		logic [15:0] closing;
	} cbm_job_t;

endpackage

>>> rtl/core/cbm_front.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_front: event intake and classification
// Keeps own speed and speed limit, decides speed-limit brakes at once, hands
// cars with positive closing speed and nonzero distance on as divide jobs.
// ---------------------------------------------------------------------------
module cbm_front import cbm_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic [1:0]         in_cmd,
	input  logic signed [15:0] in_speed,
	input  logic [15:0]        in_distance,
	input  logic               queue_full,
	output logic               in_ready,
	output logic               push,
	output cbm_job_t           push_job
);

	logic signed [15:0] own_speed_q;
	logic signed [15:0] limit_q;
	logic               limit_seen_q;
	logic               accept;
	logic signed [16:0] closing;
	logic               car_push;
	logic               zero_push;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign closing  = {own_speed_q[15], own_speed_q} - {in_speed[15], in_speed};

	always_comb begin
		car_push  = 1'b0;
		zero_push = 1'b0;
		case (in_cmd)
			CMD_SPEED: zero_push = limit_seen_q && (in_speed > limit_q);
			CMD_CAR: car_push = !closing[16] && (closing != 17'sd0) &&
					(in_distance != 16'd0);
			CMD_LIMIT: zero_push = own_speed_q > in_speed;
			default: begin
				car_push  = 1'b0;
				zero_push = 1'b0;
			end
		endcase
	end

	assign push              = accept && (car_push || zero_push);
	assign push_job.op       = car_push ? JOB_DIVIDE : JOB_ZERO;
	assign push_job.distance = in_distance;
	assign push_job.closing  = closing[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_speed_q  <= '0;
			limit_q      <= LIMIT_RESET;
			limit_seen_q <= 1'b0;
		end else if (accept) begin
			if (in_cmd == CMD_SPEED) begin
				own_speed_q <= in_speed;
			end
			if (in_cmd == CMD_LIMIT) begin
				limit_q      <= in_speed;
				limit_seen_q <= 1'b1;
			end
		end
	end

endmodule

>>> rtl/core/cbm_queue.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_queue: job queue between front end and back end
// A small first-in first-out buffer of classified jobs.
// ---------------------------------------------------------------------------
module cbm_queue import cbm_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  cbm_job_t push_job,
	input  logic     pop,
	output logic     full,
	output logic     not_empty,
	output cbm_job_t head_job
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	cbm_job_t        mem_q [DEPTH];
	logic [PW-1:0]   wr_ptr_q;
	logic [PW-1:0]   rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign full      = count_q == CW'(DEPTH);
	assign not_empty = count_q != '0;
	assign head_job  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("queue count exceeds depth");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0)
		else $error("pop from empty queue");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("push without pop did not grow the queue");
`endif

endmodule

>>> rtl/core/cbm_back.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cbm_back: brake decision and time-to-collision divider
// Checks a divide job against the threshold, runs a 16-step restoring
// division and holds the result in the output register.
// ---------------------------------------------------------------------------
module cbm_back import cbm_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] threshold,
	input  logic        job_valid,
	input  cbm_job_t    job,
	output logic        job_pop,
	output logic        out_valid,
	output logic [15:0] out_time,
	input  logic        out_ready
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_CMP,
		ST_DIV,
		ST_DONE
	} state_t;

	state_t      state_q;
	cbm_job_t    job_q;
	logic [31:0] prod_q;
	logic [15:0] rem_q;
	logic [15:0] num_lo_q;
	logic [15:0] quot_q;
	logic [3:0]  step_q;
	logic        out_valid_q;
	logic [15:0] out_time_q;
	logic [16:0] trial;
	logic        qbit;
	logic        out_free;

	assign job_pop   = (state_q == ST_IDLE) && job_valid;
	assign out_valid = out_valid_q;
	assign out_time  = out_time_q;
	assign out_free  = !out_valid_q || out_ready;

	assign trial = {rem_q, num_lo_q[15]};
	assign qbit  = trial >= {1'b0, job_q.closing};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			job_q       <= '0;
			prod_q      <= '0;
			rem_q       <= '0;
			num_lo_q    <= '0;
			quot_q      <= '0;
			step_q      <= '0;
			out_time_q  <= '0;
		end else begin
			// In the done state the output register is reloaded below instead.
			if (out_valid_q && out_ready && (state_q != ST_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_valid) begin
						job_q  <= job;
						quot_q <= '0;
						state_q <= (job.op == JOB_DIVIDE) ? ST_MUL : ST_DONE;
					end
				end
				ST_MUL: begin
					prod_q  <= {16'd0, threshold} * {16'd0, job_q.closing};
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					// The exact ratio decides; a passing job has a quotient
					// below 2^16, so the upper numerator bits start the remainder.
					if ({4'd0, job_q.distance, 12'd0} > prod_q) begin
						state_q <= ST_IDLE;
					end else begin
						rem_q    <= {4'd0, job_q.distance[15:4]};
						num_lo_q <= {job_q.distance[3:0], 12'd0};
						step_q   <= '0;
						state_q  <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q    <= qbit ? 16'(trial - {1'b0, job_q.closing}) : trial[15:0];
					num_lo_q <= {num_lo_q[14:0], 1'b0};
					quot_q   <= {quot_q[14:0], qbit};
					step_q   <= step_q + 1'b1;
					if (step_q == 4'd15) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						out_time_q  <= quot_q;
						state_q     <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> rtl/core/collision_brake_monitor.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// collision_brake_monitor: time-to-collision brake monitor
// Turns own-speed, detected-car and speed-limit events into brake commands.
// ---------------------------------------------------------------------------
// Usage:
//   Events arrive on the s_ stream: tuser carries the event kind, tdata the
//   signed speed (Q8.8 m/s) and the distance (Q12.4 m). Brake commands leave
//   on the m_ stream with the time to collision in Q8.8 seconds, zero for a
//   speed-limit brake. Events that do not brake produce no transfer.
//   Speed and limit events update state in the cycle they are accepted; a
//   resulting zero-time brake goes through the job queue and the back end's
//   done state when the back end is idle. A detected car in the back end
//   takes one job pop, a multiply and a compare for the threshold check,
//   then a 16-step restoring divider producing one quotient bit per cycle.
//   The divider sets the car event rate: no new job starts before the last is done.
//   A job queue of QUEUE_DEPTH entries lets the front end keep taking events
//   while the divider works; s_tready drops when the queue is full.
//   If the receiver stalls, the result waits in the output register and the
//   back end holds its next finished result until that one is taken.
//   The threshold register sits at APB address 0; writes below one second
//   are ignored. Reset sets the threshold to 5 s, own speed to zero, the
//   limit to 39 m/s unseen, and empties the queue.
// ---------------------------------------------------------------------------
module collision_brake_monitor import cbm_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [15:0] speed_value, [31:16] distance
	input  logic [1:0]  s_tuser,  // [1:0] cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,  // [15:0] time_to_collision
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [15:0] threshold_q;
	logic        push;
	cbm_job_t    push_job;
	logic        queue_full;
	logic        queue_not_empty;
	cbm_job_t    head_job;
	logic        pop;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_THRESHOLD) ? {16'd0, threshold_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RESET;
		end else if (psel && penable && pwrite && pready &&
				(paddr[2] == REG_THRESHOLD) && (pwdata[15:0] >= THRESHOLD_MIN)) begin
			threshold_q <= pwdata[15:0];
		end
	end

	cbm_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_cmd      (s_tuser),
		.in_speed    (s_tdata[15:0]),
		.in_distance (s_tdata[31:16]),
		.queue_full  (queue_full),
		.in_ready    (s_tready),
		.push        (push),
		.push_job    (push_job)
	);

	cbm_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_job  (push_job),
		.pop       (pop),
		.full      (queue_full),
		.not_empty (queue_not_empty),
		.head_job  (head_job)
	);

	cbm_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.threshold (threshold_q),
		.job_valid (queue_not_empty),
		.job       (head_job),
		.job_pop   (pop),
		.out_valid (m_tvalid),
		.out_time  (m_tdata),
		.out_ready (m_tready)
	);

endmodule
